FILE: rtl/cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants for the cubic Bezier spline sampler.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int T_FRAC_BITS = 16;
  localparam int PT_WIDTH    = COORD_WIDTH + 1;   // control point width
  localparam int CNT_WIDTH   = 7;
  localparam int IDX_WIDTH   = 6;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic CFG_CLOSED = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PT_WIDTH-1:0]    point_t;

  typedef struct packed {
    logic                   command;
    logic [IDX_WIDTH-1:0]   entry_index;
    coord_t                 point_x;
    coord_t                 point_y;
    coord_t                 point_z;
    coord_t                 in_offset_x;
    coord_t                 in_offset_y;
    coord_t                 in_offset_z;
    coord_t                 out_offset_x;
    coord_t                 out_offset_y;
    coord_t                 out_offset_z;
    logic [T_FRAC_BITS-1:0] sample_position;
  } in_word_t;

  typedef struct packed {
    coord_t curve_x;
    coord_t curve_y;
    coord_t curve_z;
    logic   fault;
  } out_word_t;

  // one knot as stored: anchor, incoming and outgoing offsets, x y z each
  typedef struct packed {
    coord_t [2:0] anchor;
    coord_t [2:0] in_ofs;
    coord_t [2:0] out_ofs;
  } knot_t;

endpackage

FILE: rtl/cbs_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_lerp
// One registered linear interpolation step with round-half-up at u.
// ----------------------------------------------------------------------------
module cbs_lerp (
  input  logic                            clk,
  input  logic                            en,
  input  cbs_pkg::point_t                 a,
  input  cbs_pkg::point_t                 b,
  input  logic [cbs_pkg::T_FRAC_BITS-1:0] u,
  output cbs_pkg::point_t                 y_r
);

  localparam int DW = cbs_pkg::PT_WIDTH + 1;
  localparam int UW = cbs_pkg::T_FRAC_BITS + 1;
  localparam int PW = DW + UW;

  logic signed [DW-1:0] diff;
  logic signed [UW-1:0] u_s;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] step;
  logic signed [PW-1:0] sum;
  cbs_pkg::point_t      y_nxt;

  // a + (b - a) * u, the product rounded, floored back to coordinate scale
  always_comb begin
    diff  = DW'(b) - DW'(a);
    u_s   = $signed({1'b0, u});
    prod  = PW'(diff) * PW'(u_s) + PW'(1 << (cbs_pkg::T_FRAC_BITS - 1));
    step  = prod >>> cbs_pkg::T_FRAC_BITS;
    sum   = PW'(a) + step;
    y_nxt = sum[cbs_pkg::PT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

endmodule

FILE: rtl/cubic_bezier_spline_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_spline_sampler
// Knot table with a five-stage cubic Bezier evaluation pipeline.
// ----------------------------------------------------------------------------
// Takes one word per cycle, unless stalled, and returns one result word per
// input word, in order, after a knot table read, control point forming and
// three de Casteljau interpolation levels, one per stage. The whole pipeline
// holds while the output word is stalled. Knot writes land at acceptance, so
// a sample right behind a write sees the new knot. Knots never written read
// as undefined values. The configuration port is always ready.
module cubic_bezier_spline_sampler #(
  parameter int MAX_KNOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbs_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output cbs_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [cbs_pkg::CNT_WIDTH-1:0] cfg_data
);

  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int CW = cbs_pkg::COORD_WIDTH;
  localparam int TW = cbs_pkg::T_FRAC_BITS;
  localparam int NW = cbs_pkg::CNT_WIDTH;
  localparam int SW = TW + NW;

  // configuration registers
  logic          closed_r;
  logic [NW-1:0] count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= 1'b0;
      count_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cbs_pkg::CFG_CLOSED: closed_r <= cfg_data[0];
        cbs_pkg::CFG_COUNT:  count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic acc;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  assign en       = !(v5_r && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;

  // segment decode
  logic [SW-1:0] scaled;
  logic [NW-1:0] seg_k;
  logic [NW-1:0] seg_n;
  logic [TW-1:0] seg_u;
  logic          fault0;
  logic          zero0;
  always_comb begin
    scaled = SW'(in_word.sample_position) * SW'(count_r);
    seg_k  = scaled[SW-1:TW];
    seg_u  = scaled[TW-1:0];
    seg_n  = seg_k + NW'(1);
    if (closed_r && (seg_n == count_r)) begin
      seg_n = '0;
    end
    if (in_word.command == cbs_pkg::CMD_WRITE) begin
      fault0 = (32'(in_word.entry_index) >= MAX_KNOTS);
      zero0  = 1'b1;
    end else begin
      fault0 = (count_r == '0) || (32'(count_r) > MAX_KNOTS) ||
               (seg_k >= count_r) || (seg_n >= count_r);
      zero0  = fault0;
    end
  end

  // knot memory: one write port, two registered read ports
  cbs_pkg::knot_t knot_mem [MAX_KNOTS];
  cbs_pkg::knot_t ks_r, ke_r;
  cbs_pkg::knot_t wr_knot;
  assign wr_knot.anchor  = {in_word.point_z, in_word.point_y, in_word.point_x};
  assign wr_knot.in_ofs  = {in_word.in_offset_z, in_word.in_offset_y, in_word.in_offset_x};
  assign wr_knot.out_ofs = {in_word.out_offset_z, in_word.out_offset_y,
                            in_word.out_offset_x};

  always_ff @(posedge clk) begin
    if (acc && (in_word.command == cbs_pkg::CMD_WRITE) && !fault0) begin
      knot_mem[AW'(in_word.entry_index)] <= wr_knot;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ks_r <= knot_mem[AW'(seg_k)];
      ke_r <= knot_mem[AW'(seg_n)];
    end
  end

  // control flags and local parameter along the pipe
  logic          z1_r, z2_r, z3_r, z4_r, z5_r;
  logic          f1_r, f2_r, f3_r, f4_r, f5_r;
  logic [TW-1:0] u1_r, u2_r, u3_r, u4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r <= zero0; z2_r <= z1_r; z3_r <= z2_r; z4_r <= z3_r; z5_r <= z4_r;
      f1_r <= fault0; f2_r <= f1_r; f3_r <= f2_r; f4_r <= f3_r; f5_r <= f4_r;
      u1_r <= seg_u; u2_r <= u1_r; u3_r <= u2_r; u4_r <= u3_r;
    end
  end

  // per coordinate: control points, then three interpolation levels
  cbs_pkg::point_t p0_r [3];
  cbs_pkg::point_t p1_r [3];
  cbs_pkg::point_t p2_r [3];
  cbs_pkg::point_t p3_r [3];
  cbs_pkg::point_t la_r [3];
  cbs_pkg::point_t lb_r [3];
  cbs_pkg::point_t lc_r [3];
  cbs_pkg::point_t ld_r [3];
  cbs_pkg::point_t le_r [3];
  cbs_pkg::point_t lf_r [3];
  cbs_pkg::coord_t res  [3];

  for (genvar j = 0; j < 3; j++) begin : g_coord
    always_ff @(posedge clk) begin
      if (en) begin
        p0_r[j] <= (CW+1)'(ks_r.anchor[j]);
        p1_r[j] <= (CW+1)'(ks_r.anchor[j]) + (CW+1)'(ks_r.out_ofs[j]);
        p2_r[j] <= (CW+1)'(ke_r.anchor[j]) + (CW+1)'(ke_r.in_ofs[j]);
        p3_r[j] <= (CW+1)'(ke_r.anchor[j]);
      end
    end

    cbs_lerp u_la (.clk(clk), .en(en), .a(p0_r[j]), .b(p1_r[j]), .u(u2_r), .y_r(la_r[j]));
    cbs_lerp u_lb (.clk(clk), .en(en), .a(p1_r[j]), .b(p2_r[j]), .u(u2_r), .y_r(lb_r[j]));
    cbs_lerp u_lc (.clk(clk), .en(en), .a(p2_r[j]), .b(p3_r[j]), .u(u2_r), .y_r(lc_r[j]));
    cbs_lerp u_ld (.clk(clk), .en(en), .a(la_r[j]), .b(lb_r[j]), .u(u3_r), .y_r(ld_r[j]));
    cbs_lerp u_le (.clk(clk), .en(en), .a(lb_r[j]), .b(lc_r[j]), .u(u3_r), .y_r(le_r[j]));
    cbs_lerp u_lf (.clk(clk), .en(en), .a(ld_r[j]), .b(le_r[j]), .u(u4_r), .y_r(lf_r[j]));

    // saturate to coordinate range, zero on write or fault
    always_comb begin
      if (z5_r) begin
        res[j] = '0;
      end else if (lf_r[j][CW] != lf_r[j][CW-1]) begin
        res[j] = lf_r[j][CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        res[j] = lf_r[j][CW-1:0];
      end
    end
  end

  assign out_valid        = v5_r;
  assign out_word.curve_x = res[0];
  assign out_word.curve_y = res[1];
  assign out_word.curve_z = res[2];
  assign out_word.fault   = f5_r;

endmodule
